// ===== rtl/mskf_pkg.sv =====
// mskf_pkg: widths, reset values, codes and controller/datapath interface types
// for the multichannel scalar kalman filter. no dependencies.
`timescale 1ns / 1ps

package mskf_pkg;

    localparam int CHANNELS   = 8;
    localparam int CH_IW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_W       = 3;
    localparam int SAMPLE_W   = 16;
    localparam int EST_W      = 31;
    localparam int COV_W      = 32;
    localparam int NOISE_W    = 32;
    localparam int GAIN_W     = 32;
    localparam int DEN_W      = 33;
    localparam int REM_W      = 33;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 64;
    localparam int FRAC_SH    = 31;
    localparam int DIV_STEPS  = 31;
    localparam int CNT_W      = 5;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [MUL_W-1:0]   SCALE_MUL    = 32'd20480;
    localparam logic [COV_W-1:0]   COV_RESET    = 32'd21474836;
    localparam logic [NOISE_W-1:0] PNOISE_RESET = 32'd1073742;
    localparam logic [NOISE_W-1:0] MNOISE_RESET = 32'd5368709;
    localparam logic [GAIN_W-1:0]  ONE_Q31      = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PNOISE = 1'b0,
        CFG_MNOISE = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MUL_SCALE,
        MUL_GAIN,
        MUL_COV
    } t_mul_sel;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_SETUP,
        ST_DIV,
        ST_MUL_E,
        ST_MUL_P,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic     load;
        logic     pred;
        logic     setup;
        logic     div_step;
        logic     mul_gain;
        logic     upd_est;
        logic     commit;
        logic     mul_en;
        t_mul_sel mul_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/mskf_ctrl.sv =====
// mskf_ctrl: sequencer for one filter update; drives the datapath commands
// and counts the divider steps. depends on mskf_pkg.
`timescale 1ns / 1ps

module mskf_ctrl import mskf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               w_div_last;

    assign w_div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_PRED;
            end
            ST_PRED:  n_state = ST_SETUP;
            ST_SETUP: n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_last) begin
                    n_state = ST_MUL_E;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_MUL_E: n_state = ST_MUL_P;
            ST_MUL_P: n_state = ST_DONE;
            ST_DONE: begin
                // hold the result until the output register can take it
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.mul_sel = MUL_SCALE;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_PRED: begin
                o_cmd.pred    = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_SCALE;
            end
            ST_SETUP: o_cmd.setup = 1'b1;
            ST_DIV:   o_cmd.div_step = 1'b1;
            ST_MUL_E: begin
                o_cmd.mul_gain = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MUL_GAIN;
            end
            ST_MUL_P: begin
                o_cmd.upd_est = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_COV;
            end
            ST_DONE:  o_cmd.commit = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/mskf_dp.sv =====
// mskf_dp: per-channel state, noise registers, shared multiplier, radix-2
// gain divider and output register. depends on mskf_pkg.
`timescale 1ns / 1ps

module mskf_dp import mskf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [CH_W-1:0]       i_channel,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [CH_W-1:0]       o_out_channel,
    output logic [EST_W-1:0]      o_filtered
);

    logic [NOISE_W-1:0]  r_pnoise;
    logic [NOISE_W-1:0]  r_mnoise;
    logic [EST_W-1:0]    r_est [CHANNELS];
    logic [COV_W-1:0]    r_cov [CHANNELS];

    logic [CH_W-1:0]     r_ch;
    logic [SAMPLE_W-1:0] r_sample;
    logic [EST_W-1:0]    r_e;
    logic [COV_W-1:0]    r_n;
    logic [DEN_W-1:0]    r_den;
    logic                r_zero;
    logic [REM_W-1:0]    r_rem;
    logic [GAIN_W-1:0]   r_q;
    logic [EST_W-1:0]    r_diff;
    logic                r_xge;
    logic [GAIN_W-1:0]   r_kc;
    logic [EST_W-1:0]    r_enew;
    logic [PROD_W-1:0]   r_prod;

    logic                r_ovalid;
    logic [CH_W-1:0]     r_och;
    logic [EST_W-1:0]    r_ofilt;

    logic [CH_IW-1:0]    w_idx;
    logic                w_ok;
    logic [COV_W:0]      w_sum;
    logic [COV_W-1:0]    w_n;
    logic [DEN_W-1:0]    w_den;
    logic                w_qtop;
    logic [EST_W-1:0]    w_x;
    logic                w_xge;
    logic [EST_W-1:0]    w_diff;
    logic [REM_W:0]      w_rem2;
    logic [REM_W:0]      w_rsub;
    logic                w_dge;
    logic [GAIN_W-1:0]   w_k;
    logic [MUL_W-1:0]    w_mul_a;
    logic [MUL_W-1:0]    w_mul_b;
    logic [EST_W-1:0]    w_corr;
    logic [COV_W-1:0]    w_pnew;

    assign w_idx = CH_IW'(r_ch);
    assign w_ok  = (32'(r_ch) < 32'(CHANNELS));

    // prediction, saturated at all ones
    assign w_sum = {1'b0, r_cov[w_idx]} + {1'b0, r_pnoise};
    assign w_n   = w_sum[COV_W] ? '1 : w_sum[COV_W-1:0];

    // integer bit of the gain is set only when the measurement noise is zero
    assign w_den  = {1'b0, r_n} + {1'b0, r_mnoise};
    assign w_qtop = (r_mnoise == '0);

    assign w_x    = r_prod[EST_W-1:0];
    assign w_xge  = (w_x >= r_e);
    assign w_diff = w_xge ? (w_x - r_e) : (r_e - w_x);

    assign w_rem2 = {r_rem, 1'b0};
    assign w_rsub = w_rem2 - {1'b0, r_den};
    assign w_dge  = (w_rem2 >= {1'b0, r_den});

    assign w_k = r_zero ? '0 : r_q;

    assign w_corr = r_prod[EST_W+FRAC_SH-1:FRAC_SH];
    assign w_pnew = r_prod[COV_W+FRAC_SH-1:FRAC_SH];

    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_SCALE: begin
                w_mul_a = MUL_W'(r_sample);
                w_mul_b = SCALE_MUL;
            end
            MUL_GAIN: begin
                w_mul_a = MUL_W'(r_diff);
                w_mul_b = w_k;
            end
            MUL_COV: begin
                w_mul_a = r_kc;
                w_mul_b = r_n;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pnoise <= PNOISE_RESET;
            r_mnoise <= MNOISE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_PNOISE: r_pnoise <= i_cfg_data;
                CFG_MNOISE: r_mnoise <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_est[i] <= '0;
                r_cov[i] <= COV_RESET;
            end
        end else if (i_cmd.commit && w_ok) begin
            r_est[w_idx] <= r_enew;
            r_cov[w_idx] <= w_pnew;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch     <= i_channel;
            r_sample <= i_sample;
        end
        if (i_cmd.pred) begin
            r_e <= r_est[w_idx];
            r_n <= w_n;
        end
        if (i_cmd.setup) begin
            r_den  <= w_den;
            r_zero <= (w_den == '0);
            r_rem  <= w_qtop ? '0 : REM_W'(r_n);
            r_q    <= GAIN_W'(w_qtop);
            r_diff <= w_diff;
            r_xge  <= w_xge;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_dge ? w_rsub[REM_W-1:0] : w_rem2[REM_W-1:0];
            r_q   <= {r_q[GAIN_W-2:0], w_dge};
        end
        if (i_cmd.mul_gain) begin
            r_kc <= ONE_Q31 - w_k;
        end
        if (i_cmd.upd_est) begin
            r_enew <= r_xge ? (r_e + w_corr) : (r_e - w_corr);
        end
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_och   <= r_ch;
            r_ofilt <= w_ok ? r_enew : '0;
        end
    end

    assign o_sts.out_free = !r_ovalid || i_out_ready;
    assign o_out_valid    = r_ovalid;
    assign o_out_channel  = r_och;
    assign o_filtered     = r_ofilt;

endmodule

// ===== rtl/multichannel_scalar_kalman_filter_top.sv =====
// multichannel_scalar_kalman_filter_top: top level, joins the sequencer and the
// datapath and packs the stream buses. depends on mskf_pkg, mskf_ctrl, mskf_dp.
//
//  channel  direction  ports                            payload
//  -------  ---------  -------------------------------  ------------------------------
//  s        in         i_s_tvalid o_s_tready i_s_tdata   channel, sample
//  m        out        o_m_tvalid i_m_tready o_m_tdata   out_channel, filtered
//  cfg      in         i_cfg_we i_cfg_idx i_cfg_data     process_noise, measure_noise
//
// an item goes from acceptance through prediction, setup, the bit-per-cycle gain
// divider and two multiplies to done; a new item is taken only back in idle.
// reset is synchronous, active low; it restores the noise defaults, clears every
// channel's estimate and sets every covariance to COV_RESET at once.
// a result sits in the output register while the next item is accepted and
// processed; only a finished result that meets a full output register waits.
`timescale 1ns / 1ps

module multichannel_scalar_kalman_filter_top import mskf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [2:0] channel, [18:3] sample
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // [2:0] out_channel, [33:3] filtered
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_dp_cmd           w_cmd;
    t_dp_sts           w_sts;
    logic [CH_W-1:0]   w_out_ch;
    logic [EST_W-1:0]  w_filt;

    mskf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mskf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_channel     (i_s_tdata[CH_W-1:0]),
        .i_sample      (i_s_tdata[CH_W+SAMPLE_W-1:CH_W]),
        .i_out_ready   (i_m_tready),
        .o_out_valid   (o_m_tvalid),
        .o_out_channel (w_out_ch),
        .o_filtered    (w_filt)
    );

    assign o_m_tdata = {(OUT_TDATA_W - CH_W - EST_W)'(0), w_filt, w_out_ch};

endmodule
